>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is high.
`define SALC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define SALC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/salc_pkg.sv
// Shared constants and codes of the set-associative LRU cache simulator.
package salc_pkg;

   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 32;
   localparam int OUTCOME_W = 2;
   localparam int CNT_W     = 32;

   localparam int SET_BITS_W   = 3;
   localparam int BLOCK_BITS_W = 5;
   localparam int WAYS_W       = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_IFETCH = 2'd3;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

endpackage

>>> hdl/salc_if.sv
// Valid/ready channel interfaces for trace accesses and lookup results.
interface salc_req_if
   import salc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output command, output address, input ready);
   modport sink   (input valid, input command, input address, output ready);
endinterface

interface salc_rsp_if
   import salc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 modify_hit;
   logic [CNT_W-1:0]     total_hits;
   logic [CNT_W-1:0]     total_misses;
   logic [CNT_W-1:0]     total_evictions;

   modport source (output valid, output outcome, output modify_hit, output total_hits,
                   output total_misses, output total_evictions, input ready);
   modport sink   (input valid, input outcome, input modify_hit, input total_hits,
                   input total_misses, input total_evictions, output ready);
endinterface

>>> hdl/set_assoc_lru_cache_sim.sv
// Top level: set-associative LRU cache simulator built around one set-wide memory.
// For a data access (load, store, modify), the accept edge reads the
// whole set (all ways' tags, valid bits and LRU ranks) from the set memory into a
// register, and the lookup edge compares tags, picks the way and writes the set
// back while the result is registered. The lookup edge waits while an earlier
// result is still untaken. An instruction fetch is accepted but gives no result.
// After reset, and after every write to one of the three configuration registers,
// a clearing pass writes each set once, during which no item is accepted. Hit,
// miss and eviction totals saturate and survive configuration writes.
module set_assoc_lru_cache_sim
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   salc_req_if.sink              req_chan,
   salc_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SETS    = 1 << MAX_SET_BITS;
   localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
   localparam int SHIFT_W = 6;

   typedef struct packed {
      logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
   } set_word_type;

   typedef enum logic {ST_IDLE, ST_LOOK} state_type;

   state_type              state_ff, state_in;
   logic [SET_BITS_W-1:0]   set_bits_ff;
   logic [BLOCK_BITS_W-1:0] block_bits_ff;
   logic [WAYS_W-1:0]       ways_ff;

   logic                   clr_active_ff;
   logic [SET_W-1:0]       clr_idx_ff;

   set_word_type           mem [SETS];
   set_word_type           rd_ff;
   logic [SET_W-1:0]       set_ff;
   logic [ADDR_W-1:0]      tag_ff;
   logic                   modify_ff;

   logic                   rsp_valid_ff;
   logic [OUTCOME_W-1:0]   outcome_ff, outcome_in;
   logic                   modify_hit_ff;
   logic [CNT_W-1:0]       hits_ff, hits_in;
   logic [CNT_W-1:0]       misses_ff, misses_in;
   logic [CNT_W-1:0]       evicts_ff, evicts_in;

   logic [SET_BITS_W-1:0]  eff_sb;
   logic [WCNT_W-1:0]      nw;
   logic [SET_W-1:0]       set_mask;
   logic [SET_W-1:0]       set_idx;
   logic [ADDR_W-1:0]      addr_shifted;
   logic [2*ADDR_W-1:0]    tag_wide;
   logic [SHIFT_W-1:0]     tag_shift;

   logic                   req_fire;
   logic                   data_fire;
   logic                   look_go;
   logic                   cfg_clear;

   logic [MAX_WAYS-1:0]    in_use, hit_vec, free_vec, vict_vec;
   logic                   is_hit, is_free;
   logic [RANK_W-1:0]      hit_way, free_way, vict_way, sel_way;
   logic [RANK_W-1:0]      old_rank;
   set_word_type           upd_word, clr_word;

   logic                   wr_en;
   logic [SET_W-1:0]       wr_addr;
   set_word_type           wr_data;

   function automatic logic [RANK_W-1:0] first_set(input logic [MAX_WAYS-1:0] vec);
      logic [RANK_W-1:0] idx;
      idx = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (vec[w]) idx = RANK_W'(w);
      end
      return idx;
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                input logic [1:0]       inc);
      logic [CNT_W:0] sum;
      sum = {1'b0, cnt} + (CNT_W + 1)'(inc);
      return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
   endfunction

   // effective configuration
   assign eff_sb = (int'(set_bits_ff) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS)
                                                      : set_bits_ff;
   always_comb begin
      if (ways_ff == '0) begin
         nw = WCNT_W'(1);
      end else if ((WAYS_W + 1)'(ways_ff) > (WAYS_W + 1)'(MAX_WAYS)) begin
         nw = WCNT_W'(MAX_WAYS);
      end else begin
         nw = WCNT_W'(ways_ff);
      end
   end

   // address split
   always_comb begin
      for (int i = 0; i < SET_W; i++) begin
         set_mask[i] = (i < int'(eff_sb));
      end
   end
   assign addr_shifted = req_chan.address >> block_bits_ff;
   assign set_idx      = addr_shifted[SET_W-1:0] & set_mask;
   assign tag_shift    = SHIFT_W'(eff_sb) + SHIFT_W'(block_bits_ff);
   assign tag_wide     = {{ADDR_W{1'b0}}, req_chan.address} >> tag_shift;

   assign req_chan.ready = (state_ff == ST_IDLE) && !clr_active_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign data_fire      = req_fire && (req_chan.command != CMD_IFETCH);
   assign look_go        = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_chan.ready);
   assign cfg_clear      = csr_we && (csr_index == CSR_SET_BITS ||
                                      csr_index == CSR_BLOCK_BITS ||
                                      csr_index == CSR_WAYS);

   // lookup on the set word
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]   = WCNT_W'(w) < nw;
         hit_vec[w]  = in_use[w] && rd_ff.valid[w] && (rd_ff.tag[w] == tag_ff);
         free_vec[w] = in_use[w] && !rd_ff.valid[w];
         vict_vec[w] = in_use[w] && (WCNT_W'(rd_ff.rank[w]) == nw - WCNT_W'(1));
      end
   end

   assign is_hit   = |hit_vec;
   assign is_free  = |free_vec;
   assign hit_way  = first_set(hit_vec);
   assign free_way = first_set(free_vec);
   assign vict_way = first_set(vict_vec);
   assign sel_way  = is_hit ? hit_way : (is_free ? free_way : vict_way);
   assign old_rank = rd_ff.rank[sel_way];

   always_comb begin
      upd_word = rd_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (in_use[w] && (rd_ff.rank[w] < old_rank)) begin
            upd_word.rank[w] = rd_ff.rank[w] + RANK_W'(1);
         end
      end
      upd_word.rank[sel_way] = '0;
      if (!is_hit) begin
         upd_word.tag[sel_way]   = tag_ff;
         upd_word.valid[sel_way] = 1'b1;
      end
   end

   always_comb begin
      clr_word = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         clr_word.rank[w] = RANK_W'(w);
      end
   end

   always_comb begin
      outcome_in = is_hit ? OUTCOME_HIT : (is_free ? OUTCOME_FILL : OUTCOME_EVICT);
      hits_in    = sat_add(hits_ff, {1'b0, is_hit} + {1'b0, modify_ff});
      misses_in  = sat_add(misses_ff, {1'b0, !is_hit});
      evicts_in  = sat_add(evicts_ff, {1'b0, !is_hit && !is_free});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (data_fire) state_in = ST_LOOK;
         ST_LOOK: if (look_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign wr_en   = look_go || clr_active_ff;
   assign wr_addr = clr_active_ff ? clr_idx_ff : set_ff;
   assign wr_data = clr_active_ff ? clr_word : upd_word;

   // set memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (data_fire) begin
         rd_ff <= mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= WAYS_W'(1);
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SET_BITS:   set_bits_ff   <= csr_data[SET_BITS_W-1:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_data[BLOCK_BITS_W-1:0];
               CSR_WAYS:       ways_ff       <= csr_data[WAYS_W-1:0];
               default: ;
            endcase
         end
         if (cfg_clear) begin
            clr_active_ff <= 1'b1;
            clr_idx_ff    <= '0;
         end else if (clr_active_ff) begin
            if (clr_idx_ff == SET_W'(SETS - 1)) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_idx_ff <= clr_idx_ff + SET_W'(1);
            end
         end
         if (look_go) begin
            rsp_valid_ff <= 1'b1;
            hits_ff      <= hits_in;
            misses_ff    <= misses_in;
            evicts_ff    <= evicts_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (data_fire) begin
         set_ff    <= set_idx;
         tag_ff    <= tag_wide[ADDR_W-1:0];
         modify_ff <= (req_chan.command == CMD_MODIFY);
      end
      if (look_go) begin
         outcome_ff    <= outcome_in;
         modify_hit_ff <= modify_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.outcome         = outcome_ff;
   assign rsp_chan.modify_hit      = modify_hit_ff;
   assign rsp_chan.total_hits      = hits_ff;
   assign rsp_chan.total_misses    = misses_ff;
   assign rsp_chan.total_evictions = evicts_ff;

endmodule

>>> hdl/salc_checker.sv
// Port-level checker for the cache simulator, bound to the top level.
`include "assert_macros.svh"

module salc_checker
   import salc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [CMD_W-1:0]     req_command,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUTCOME_W-1:0] rsp_outcome,
   input logic [CNT_W-1:0]     rsp_total_hits,
   input logic [CNT_W-1:0]     rsp_total_misses
);

   property p_outcome_code;
      rsp_valid |-> (rsp_outcome == OUTCOME_HIT || rsp_outcome == OUTCOME_FILL ||
                     rsp_outcome == OUTCOME_EVICT);
   endproperty

   property p_totals_rise;
      ##1 (rsp_total_hits >= $past(rsp_total_hits) &&
           rsp_total_misses >= $past(rsp_total_misses));
   endproperty

   property p_access_answered;
      req_valid && req_ready && req_command != CMD_IFETCH && !rsp_valid |-> ##2 rsp_valid;
   endproperty

   `SALC_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result after reset")

   `SALC_ASSERT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")

   `SALC_ASSERT(a_outcome_code, clock, reset, p_outcome_code, "bad outcome")

   `SALC_ASSERT(a_totals_rise, clock, reset, p_totals_rise, "total fell")

   `SALC_ASSERT(a_access_answered, clock, reset, p_access_answered, "access not answered")

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_command      (req_chan.command),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_outcome      (rsp_chan.outcome),
   .rsp_total_hits   (rsp_chan.total_hits),
   .rsp_total_misses (rsp_chan.total_misses)
);
